@@ sv/dra_pkg.sv @@
// dra_pkg: shared types, sizes and the rectangle union function
// for the damage rectangle accumulator; no dependencies
package dra_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 14;
  localparam int SIZE_W   = 15;
  localparam int OUT_W    = 17;
  localparam int SCALE_W  = 3;
  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(16384);
  localparam logic [SCALE_W-1:0] SCALE_MIN = SCALE_W'(1);
  localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(4);

  localparam logic MODE_QUEUE = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]  left;
    logic [POS_W-1:0]  top;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } rect_t;

  localparam int RECT_W = $bits(rect_t);

  typedef struct packed {
    logic append;
    logic start_merge;
    logic merge;
    logic merge_write;
    logic step;
    logic start_flush;
    logic load_out;
    logic clear;
  } dra_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic overflow;
    logic idx_last;
    logic out_last;
  } dra_status_t;

  function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W:0] v);
    sat_size = (v > {1'b0, MAX_SIZE}) ? MAX_SIZE : v[SIZE_W-1:0];
  endfunction

  function automatic rect_t rect_union(input rect_t a, input rect_t b);
    rect_t u;
    logic [SIZE_W:0] ar, br, ab, bb, rr, bot;
    u = a;
    ar  = (SIZE_W+1)'(a.left) + (SIZE_W+1)'(a.width);
    br  = (SIZE_W+1)'(b.left) + (SIZE_W+1)'(b.width);
    ab  = (SIZE_W+1)'(a.top) + (SIZE_W+1)'(a.height);
    bb  = (SIZE_W+1)'(b.top) + (SIZE_W+1)'(b.height);
    rr  = (ar > br) ? ar : br;
    bot = (ab > bb) ? ab : bb;
    if (a.width == '0 || a.height == '0) begin
      u = b;
    end else if (b.width == '0 || b.height == '0) begin
      u = a;
    end else begin
      u.left   = (a.left < b.left) ? a.left : b.left;
      u.top    = (a.top < b.top) ? a.top : b.top;
      u.width  = sat_size(rr - (SIZE_W+1)'(u.left));
      u.height = sat_size(bot - (SIZE_W+1)'(u.top));
    end
    rect_union = u;
  endfunction

endpackage

@@ sv/dra_if.sv @@
// dra_if: valid/ready channel interfaces for queue/flush items and
// flushed rectangles; depends on dra_pkg
interface dra_item_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [dra_pkg::POS_W-1:0]       rect_left;
  logic [dra_pkg::POS_W-1:0]       rect_top;
  logic [dra_pkg::SIZE_W-1:0]      rect_width;
  logic [dra_pkg::SIZE_W-1:0]      rect_height;
  logic                            buffer_select;

  modport source (output valid, mode, rect_left, rect_top, rect_width, rect_height,
                  buffer_select, input ready);
  modport sink (input valid, mode, rect_left, rect_top, rect_width, rect_height,
                buffer_select, output ready);
endinterface

interface dra_result_if;
  logic                       valid;
  logic                       ready;
  logic [dra_pkg::OUT_W-1:0]  out_left;
  logic [dra_pkg::OUT_W-1:0]  out_top;
  logic [dra_pkg::OUT_W-1:0]  out_width;
  logic [dra_pkg::OUT_W-1:0]  out_height;
  logic                       target_buffer;
  logic                       last;

  modport source (output valid, out_left, out_top, out_width, out_height,
                  target_buffer, last, input ready);
  modport sink (input valid, out_left, out_top, out_width, out_height,
                target_buffer, last, output ready);
endinterface

@@ sv/damage_rect_accumulator_unit.sv @@
// Damage rectangle accumulator, top level. Holds up to 32 rectangles in a
// registered-read RAM. A queued rectangle is appended while the store has
// room; the append that fills the store sets overflow, after which each
// queued rectangle starts a union walk over the stored entries that reads
// them one after another through a read state and an accumulate state,
// and collapses the store into one entry. A flush walks the store and emits
// one beat per entry through a read state, an output load state and an
// output state that holds on a result-side stall; the last beat is flagged
// and the store and flag are then cleared. A flush of an empty store emits
// nothing. Only one item is in work at a time. The scale setting is
// written through cfg_we/cfg_wdata; the user must write it only while idle,
// the block itself does not enforce it.
// depends on dra_pkg, dra_if, dra_ctrl, dra_dp, dra_ram
module damage_rect_accumulator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [dra_pkg::SCALE_W-1:0] cfg_wdata,
  dra_item_if.sink                    item,
  dra_result_if.source                result
);

  dra_pkg::dra_cmd_t    cmd;
  dra_pkg::dra_status_t status;

  dra_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item.valid),
    .item_mode   (item.mode),
    .item_ready  (item.ready),
    .result_valid(result.valid),
    .result_ready(result.ready),
    .status      (status),
    .cmd         (cmd)
  );

  dra_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .rect_left    (item.rect_left),
    .rect_top     (item.rect_top),
    .rect_width   (item.rect_width),
    .rect_height  (item.rect_height),
    .buffer_select(item.buffer_select),
    .cmd          (cmd),
    .status       (status),
    .out_left     (result.out_left),
    .out_top      (result.out_top),
    .out_width    (result.out_width),
    .out_height   (result.out_height),
    .target_buffer(result.target_buffer),
    .last         (result.last)
  );

endmodule

@@ sv/dra_ram.sv @@
// dra_ram: generic single write port, single read port RAM with registered read
// no dependencies
module dra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/dra_ctrl.sv @@
// dra_ctrl: controller state machine sequencing append, merge walk and flush walk
// depends on dra_pkg
module dra_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_mode,
  output logic                 item_ready,
  output logic                 result_valid,
  input  logic                 result_ready,
  input  dra_pkg::dra_status_t status,
  output dra_pkg::dra_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MRD  = 3'd1;
  localparam logic [2:0] S_MACC = 3'd2;
  localparam logic [2:0] S_MWR  = 3'd3;
  localparam logic [2:0] S_FRD  = 3'd4;
  localparam logic [2:0] S_FLD  = 3'd5;
  localparam logic [2:0] S_FOUT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign item_ready   = (state == S_IDLE);
  assign result_valid = (state == S_FOUT);
  assign accept       = item_valid && item_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (item_mode == dra_pkg::MODE_FLUSH) begin
            if (status.count_zero) begin
              cmd.clear = 1'b1;
            end else begin
              cmd.start_flush = 1'b1;
              state_next      = S_FRD;
            end
          end else if (status.overflow && !status.count_zero) begin
            cmd.start_merge = 1'b1;
            state_next      = S_MRD;
          end else begin
            cmd.append = 1'b1;
          end
        end
      end
      S_MRD: begin
        state_next = S_MACC;
      end
      S_MACC: begin
        cmd.merge = 1'b1;
        if (status.idx_last) begin
          state_next = S_MWR;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_MRD;
        end
      end
      S_MWR: begin
        cmd.merge_write = 1'b1;
        state_next      = S_IDLE;
      end
      S_FRD: begin
        state_next = S_FLD;
      end
      S_FLD: begin
        cmd.load_out = 1'b1;
        state_next   = S_FOUT;
      end
      S_FOUT: begin
        if (result_ready) begin
          if (status.out_last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.step   = 1'b1;
            state_next = S_FRD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/dra_dp.sv @@
// dra_dp: datapath with rectangle store, entry count, overflow flag, union
// accumulator, scale register and output registers; depends on dra_pkg, dra_ram
module dra_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dra_pkg::SCALE_W-1:0]   cfg_wdata,
  input  logic [dra_pkg::POS_W-1:0]     rect_left,
  input  logic [dra_pkg::POS_W-1:0]     rect_top,
  input  logic [dra_pkg::SIZE_W-1:0]    rect_width,
  input  logic [dra_pkg::SIZE_W-1:0]    rect_height,
  input  logic                          buffer_select,
  input  dra_pkg::dra_cmd_t             cmd,
  output dra_pkg::dra_status_t          status,
  output logic [dra_pkg::OUT_W-1:0]     out_left,
  output logic [dra_pkg::OUT_W-1:0]     out_top,
  output logic [dra_pkg::OUT_W-1:0]     out_width,
  output logic [dra_pkg::OUT_W-1:0]     out_height,
  output logic                          target_buffer,
  output logic                          last
);

  localparam int PROD_W = dra_pkg::OUT_W + dra_pkg::SCALE_W;

  logic [dra_pkg::CNT_W-1:0]   count;
  logic                        overflow;
  logic [dra_pkg::ADDR_W-1:0]  idx;
  logic [dra_pkg::SCALE_W-1:0] scale_cfg;
  dra_pkg::rect_t              acc;
  dra_pkg::rect_t              new_rect;
  dra_pkg::rect_t              rdata;
  dra_pkg::rect_t              wdata;
  logic                        we;
  logic [dra_pkg::ADDR_W-1:0]  waddr;
  logic [dra_pkg::SCALE_W-1:0] scale;
  logic [dra_pkg::CNT_W-1:0]   count_inc;
  logic                        idx_last;
  logic [PROD_W-1:0]           p_left, p_top, p_width, p_height;

  assign new_rect.left   = rect_left;
  assign new_rect.top    = rect_top;
  assign new_rect.width  = dra_pkg::sat_size({1'b0, rect_width});
  assign new_rect.height = dra_pkg::sat_size({1'b0, rect_height});

  assign count_inc = count + dra_pkg::CNT_W'(1);
  assign idx_last  = (dra_pkg::CNT_W'(idx) + dra_pkg::CNT_W'(1)) == count;

  assign we    = (cmd.append && count < dra_pkg::CNT_W'(dra_pkg::CAPACITY))
                 || cmd.merge_write;
  assign waddr = cmd.merge_write ? '0 : count[dra_pkg::ADDR_W-1:0];
  assign wdata = cmd.merge_write ? acc : new_rect;

  dra_ram #(
    .WIDTH(dra_pkg::RECT_W),
    .DEPTH(dra_pkg::CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx),
    .rdata(rdata)
  );

  // scale clamped to 1..4
  always_comb begin
    if (scale_cfg < dra_pkg::SCALE_MIN) begin
      scale = dra_pkg::SCALE_MIN;
    end else if (scale_cfg > dra_pkg::SCALE_MAX) begin
      scale = dra_pkg::SCALE_MAX;
    end else begin
      scale = scale_cfg;
    end
  end

  assign p_left   = PROD_W'(rdata.left) * PROD_W'(scale);
  assign p_top    = PROD_W'(rdata.top) * PROD_W'(scale);
  assign p_width  = PROD_W'(rdata.width) * PROD_W'(scale);
  assign p_height = PROD_W'(rdata.height) * PROD_W'(scale);

  assign status.count_zero = (count == '0);
  assign status.overflow   = overflow;
  assign status.idx_last   = idx_last;
  assign status.out_last   = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      overflow  <= 1'b0;
      scale_cfg <= dra_pkg::SCALE_MIN;
    end else begin
      if (cfg_we) begin
        scale_cfg <= cfg_wdata;
      end
      if (cmd.append && count < dra_pkg::CNT_W'(dra_pkg::CAPACITY)) begin
        count <= count_inc;
        if (count_inc >= dra_pkg::CNT_W'(dra_pkg::CAPACITY)) begin
          overflow <= 1'b1;
        end
      end
      if (cmd.merge_write) begin
        count <= dra_pkg::CNT_W'(1);
      end
      if (cmd.clear) begin
        count    <= '0;
        overflow <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_merge || cmd.start_flush) begin
      idx <= '0;
    end else if (cmd.step) begin
      idx <= idx + dra_pkg::ADDR_W'(1);
    end
    if (cmd.start_merge) begin
      acc <= new_rect;
    end else if (cmd.merge) begin
      acc <= dra_pkg::rect_union(acc, rdata);
    end
    if (cmd.start_flush) begin
      target_buffer <= buffer_select;
    end
    if (cmd.load_out) begin
      out_left   <= p_left[dra_pkg::OUT_W-1:0];
      out_top    <= p_top[dra_pkg::OUT_W-1:0];
      out_width  <= p_width[dra_pkg::OUT_W-1:0];
      out_height <= p_height[dra_pkg::OUT_W-1:0];
      last       <= idx_last;
    end
  end

endmodule

@@ sv/dra_check.sv @@
// dra_check: port-level checks for the damage rectangle accumulator
// and the bind that attaches them to damage_rect_accumulator_unit
module dra_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      item_ready,
  input logic                      result_valid,
  input logic                      result_ready,
  input logic [dra_pkg::OUT_W-1:0] out_left,
  input logic                      last
);

  // no new item while a result beat is pending
  a_busy_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !item_ready)
    else $error("item accepted while result pending");

  // every result beat is followed by a gap
  a_beat_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready) |=> !result_valid)
    else $error("result beat not followed by gap");

  // idle and ready right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (item_ready && !result_valid))
    else $error("not idle after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(out_left) && $stable(last)))
    else $error("stalled result beat changed");

endmodule

bind damage_rect_accumulator_unit dra_check u_dra_check (
  .clk         (clk),
  .rst         (rst),
  .item_ready  (item.ready),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .out_left    (result.out_left),
  .last        (result.last)
);
